[rtl/packed_integer_stream_decoder_top_defines.svh]
// Assertion macros for the packed integer stream decoder.
`ifndef PACKED_INTEGER_STREAM_DECODER_TOP_DEFINES_SVH
`define PACKED_INTEGER_STREAM_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PISD_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error("assertion failed");
`define PISD_ASSERT_NEVER(label, clk_sig, rst_sig, cond) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error("forbidden condition seen");
`else
`define PISD_ASSERT(label, clk_sig, rst_sig, prop)
`define PISD_ASSERT_NEVER(label, clk_sig, rst_sig, cond)
`endif
`endif

[rtl/pisd_pkg.sv]
// Shared types and constants for the packed integer stream decoder.
`default_nettype none
package pisd_pkg;
    localparam logic [2:0] MODE_U_DIRECT   = 3'd0;
    localparam logic [2:0] MODE_U_FOR      = 3'd1;
    localparam logic [2:0] MODE_ZZ_DIRECT  = 3'd2;
    localparam logic [2:0] MODE_ZZ_DELTA   = 3'd3;
    localparam logic [2:0] MODE_ZZ_FOR     = 3'd4;
    localparam logic [2:0] MODE_ZZ_DFOR    = 3'd5;
    localparam logic [2:0] MODE_DELTA_DELTA = 3'd6;

    localparam logic [2:0] REG_WIDTH = 3'd0;
    localparam logic [2:0] REG_MODE  = 3'd1;
    localparam logic [2:0] REG_COUNT = 3'd2;
    localparam logic [2:0] REG_BASE  = 3'd3;
    localparam logic [2:0] REG_FIRST = 3'd4;
    localparam logic [2:0] REG_FDELTA = 3'd5;

    // datapath operations
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1; // take new byte
    localparam logic [1:0] OP_BIT   = 2'd2; // shift one bit in, rebuild if full
    localparam logic [1:0] OP_HEAD  = 2'd3; // delta-delta head values

    typedef struct packed {
        logic [1:0] op;
        logic       head_second; // head: 0 first_value, 1 second value
        logic       emit;        // register a result
    } dp_cmd_t;

    typedef struct packed {
        logic       bits_done;   // all 8 bits of current byte consumed
        logic       count_zero;  // no values left
        logic       value_ready; // current bit completes a value
        logic       ovf;         // overflow on the value being completed
        logic       head_ovf;    // overflow on the second head value
        logic       dd_mode;
    } dp_stat_t;

    function automatic logic [63:0] zz_decode(input logic [63:0] u);
        zz_decode = {1'b0, u[63:1]} ^ {64{u[0]}};
    endfunction

    function automatic logic add_ovf(input logic [63:0] a, input logic [63:0] b,
                                     input logic [63:0] s);
        add_ovf = ~(a[63] ^ b[63]) & (a[63] ^ s[63]);
    endfunction
endpackage
`default_nettype wire

[rtl/pisd_datapath.sv]
// Bit unpacker, value rebuild and result register.
`default_nettype none
module pisd_datapath
    import pisd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic [7:0]  in_byte,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output logic [63:0]      res_value,
    output logic             res_last,
    output logic             res_ovf
);
    logic [6:0]  width_reg;
    logic [2:0]  mode_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [63:0] base_reg, fval_reg, fdel_reg;

    logic [7:0]  byte_reg;
    logic [3:0]  bitpos_reg;
    logic [63:0] acc_reg;
    logic [6:0]  gath_reg;
    logic [COUNT_BITS-1:0] left_reg;
    logic [63:0] pv_reg, pd_reg;

    logic [2:0]  m;
    logic [6:0]  w;
    logic [63:0] acc_new, zz, fa, s1, s2, rebuilt, second;
    logic        o1, o2, ovf_now, full, restart;
    logic        body_ovf, head_ovf;
    logic [6:0]  gath_inc;

    assign restart = cfg_we && (cfg_index <= REG_FDELTA);
    assign m = (mode_reg == 3'd7) ? MODE_U_DIRECT : mode_reg;
    assign w = (width_reg == 7'd0) ? 7'd1 : ((width_reg > 7'd64) ? 7'd64 : width_reg);
    assign gath_inc = gath_reg + 7'd1;
    assign full = (gath_inc >= w);

    always_comb
    begin
        acc_new = acc_reg;
        acc_new[gath_reg[5:0]] = byte_reg[bitpos_reg[2:0]];
    end

    assign zz = zz_decode(acc_new);
    assign fa = ((m == MODE_ZZ_DFOR) ? zz + base_reg : zz);
    // first adder: running delta+zz (dd) or prev_value+addend
    assign s1 = ((m == MODE_DELTA_DELTA) ? pd_reg : pv_reg) + fa;
    assign o1 = add_ovf((m == MODE_DELTA_DELTA) ? pd_reg : pv_reg, fa, s1);
    assign s2 = pv_reg + s1;
    assign o2 = add_ovf(pv_reg, s1, s2);
    assign second = fval_reg + fdel_reg;

    always_comb
    begin
        unique case (m)
            MODE_U_FOR:       rebuilt = acc_new + base_reg;
            MODE_ZZ_DIRECT:   rebuilt = zz;
            MODE_ZZ_DELTA:    rebuilt = s1;
            MODE_ZZ_FOR:      rebuilt = zz + base_reg;
            MODE_ZZ_DFOR:     rebuilt = s1;
            MODE_DELTA_DELTA: rebuilt = s2;
            default:          rebuilt = acc_new;
        endcase
    end

    always_comb
    begin
        body_ovf = 1'b0;
        if (m == MODE_ZZ_DELTA || m == MODE_ZZ_DFOR)
            body_ovf = o1;
        else if (m == MODE_DELTA_DELTA)
            body_ovf = o1 | o2;
    end

    assign head_ovf = add_ovf(fval_reg, fdel_reg, second);
    assign ovf_now  = (cmd.op == OP_HEAD) ? (cmd.head_second && head_ovf) : body_ovf;

    assign stat.bits_done   = bitpos_reg[3];
    assign stat.count_zero  = (left_reg == '0);
    assign stat.value_ready = full;
    assign stat.ovf         = body_ovf;
    assign stat.head_ovf    = head_ovf;
    assign stat.dd_mode     = (m == MODE_DELTA_DELTA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 7'd1;
            mode_reg  <= MODE_U_DIRECT;
            count_reg <= '0;
            base_reg  <= '0;
            fval_reg  <= '0;
            fdel_reg  <= '0;
            bitpos_reg <= 4'd8;
            acc_reg   <= '0;
            gath_reg  <= '0;
            left_reg  <= '0;
            pv_reg    <= '0;
            pd_reg    <= '0;
        end
        else if (restart)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg <= cfg_data[6:0];
                REG_MODE:   mode_reg  <= cfg_data[2:0];
                REG_COUNT:  count_reg <= COUNT_BITS'(cfg_data[31:0]);
                REG_BASE:   base_reg  <= cfg_data;
                REG_FIRST:  fval_reg  <= cfg_data;
                REG_FDELTA: fdel_reg  <= cfg_data;
                default:    ;
            endcase
            acc_reg  <= '0;
            gath_reg <= '0;
            left_reg <= (cfg_index == REG_COUNT) ? COUNT_BITS'(cfg_data[31:0])
                                                 : count_reg;
            pv_reg   <= '0;
            pd_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD: bitpos_reg <= 4'd0;
                OP_HEAD:
                    if (cmd.head_second)
                    begin
                        pv_reg <= second;
                        pd_reg <= fdel_reg;
                    end
                OP_BIT:
                begin
                    bitpos_reg <= bitpos_reg + 4'd1;
                    if (full)
                    begin
                        acc_reg  <= '0;
                        gath_reg <= '0;
                        left_reg <= left_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
                        if (!ovf_now)
                        begin
                            pv_reg <= s2 & {64{m == MODE_DELTA_DELTA}}
                                    | s1 & {64{m != MODE_DELTA_DELTA}};
                            if (m == MODE_DELTA_DELTA)
                                pd_reg <= s1;
                        end
                    end
                    else
                    begin
                        acc_reg  <= acc_new;
                        gath_reg <= gath_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            byte_reg <= in_byte;
        if (cmd.emit)
        begin
            if (ovf_now)
            begin
                res_value <= '0;
                res_last  <= 1'b1;
                res_ovf   <= 1'b1;
            end
            else if (cmd.op == OP_HEAD)
            begin
                res_value <= cmd.head_second ? second : fval_reg;
                res_last  <= cmd.head_second && (left_reg == '0);
                res_ovf   <= 1'b0;
            end
            else
            begin
                res_value <= rebuilt;
                res_last  <= (left_reg == {{(COUNT_BITS-1){1'b0}}, 1'b1});
                res_ovf   <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/pisd_ctrl.sv]
// Sequencer: byte intake, head values, per-bit stepping, output handshake.
`default_nettype none
module pisd_ctrl
    import pisd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic restart,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t   cmd
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_HEAD0 = 2'd1;
    localparam logic [1:0] ST_HEAD1 = 2'd2;
    localparam logic [1:0] ST_BITS  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       seen_reg, seen_next, err_reg, err_next;
    logic       ov_reg, ov_next;
    logic       slot_free;

    // result register can take a new word when empty or being drained
    assign slot_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == ST_IDLE) && !restart;

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '{op: OP_NONE, head_second: 1'b0, emit: 1'b0};
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && !restart)
                begin
                    cmd.op = OP_LOAD;
                    if (err_reg)
                        state_next = ST_IDLE;
                    else if (stat.dd_mode && !seen_reg)
                    begin
                        seen_next  = 1'b1;
                        state_next = ST_HEAD0;
                    end
                    else
                        state_next = ST_BITS;
                end
            ST_HEAD0:
                if (slot_free)
                begin
                    cmd.op = OP_HEAD;
                    cmd.emit = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_HEAD1;
                end
            ST_HEAD1:
                if (slot_free)
                begin
                    cmd.op = OP_HEAD;
                    cmd.head_second = 1'b1;
                    cmd.emit = 1'b1;
                    ov_next = 1'b1;
                    if (stat.head_ovf)
                    begin
                        err_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_BITS;
                end
            ST_BITS:
                if (stat.bits_done || stat.count_zero)
                    state_next = ST_IDLE;
                else if (!stat.value_ready || slot_free)
                begin
                    cmd.op = OP_BIT;
                    if (stat.value_ready)
                    begin
                        cmd.emit = 1'b1;
                        ov_next = 1'b1;
                        if (stat.ovf)
                        begin
                            err_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            default: state_next = ST_IDLE;
        endcase
        if (restart)
        begin
            seen_next = 1'b0;
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg  <= 1'b0;
            err_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

[rtl/packed_integer_stream_decoder_top.sv]
// Top level of the packed integer stream decoder.
// Usage:
//  s_axis: one payload byte per word (tdata[7:0] = packed_byte).
//  m_axis: one decoded value per word; tdata[63:0] = value,
//          tlast = final value of the vector, tuser = overflow flag.
//  Config: cfg_we/cfg_index/cfg_data; a write to index 0..5 restarts the vector.
//  Throughput: one byte at a time. A byte passes through an intake
//  state, one step per bit (up to 8) and a return to intake. An
//  overflow word ends the byte at once, with no return to intake; a
//  byte dropped after an error is taken in and dropped at intake.
//  The first delta-delta byte adds the head value states HEAD0 and HEAD1.
//  The per-bit shift through the accumulator sets this.
//  Latency: a value is on m_axis the cycle after its last bit is stepped.
//  Reset clears control, config and decode state; byte/result regs are not reset.
//  Receiver stall: the single result register holds its word and the
//  sequencer pauses on the next completing bit or head value until it drains.
//  After an overflow word, further bytes are accepted and dropped.
`default_nettype none
`include "packed_integer_stream_decoder_top_defines.svh"
module packed_integer_stream_decoder_top
    import pisd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] packed_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] value
    output logic             m_axis_tlast,
    output logic             m_axis_tuser    // [0] overflow
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     restart;

    assign restart = cfg_we && (cfg_index <= REG_FDELTA);

    pisd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .restart(restart),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .stat(stat), .cmd(cmd)
    );

    pisd_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_byte(s_axis_tdata), .cmd(cmd), .stat(stat),
        .res_value(m_axis_tdata), .res_last(m_axis_tlast), .res_ovf(m_axis_tuser)
    );

    // an overflow word always ends the vector
    `PISD_ASSERT(a_ovf_last, clk, rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    // overflow words carry a zero value
    `PISD_ASSERT(a_ovf_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
    // no byte intake while a config write restarts the vector
    `PISD_ASSERT_NEVER(a_cfg_block, clk, rst_n, restart && s_axis_tready)
endmodule
`default_nettype wire
